// ===== rtl/tqqd_pkg.sv =====
// Shared types and constants of the two-queue quota dispatcher.
package tqqd_pkg;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_LOADED     = 3'd0;
   localparam status_type STATUS_SIDE_FULL  = 3'd1;
   localparam status_type STATUS_DISPATCHED = 3'd2;
   localparam status_type STATUS_NOTHING    = 3'd3;
   localparam status_type STATUS_TOO_WEAK   = 3'd4;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [1:0] SEL_ORDER    = 2'd0;
   localparam logic [1:0] SEL_PRIORITY = 2'd1;
   localparam logic [1:0] SEL_LIGHT    = 2'd2;

   localparam logic [1:0] CSR_QUOTA    = 2'd0;
   localparam logic [1:0] CSR_SELECT   = 2'd1;
   localparam logic [1:0] CSR_STRENGTH = 2'd2;
   localparam logic [1:0] CSR_LENGTH   = 2'd3;

   localparam logic [1:0] CLASS_RADIO  = 2'd0;
   localparam logic [1:0] CLASS_URGENT = 2'd1;

   // fixed-point scale factors (thousandths)
   localparam int K_STRENGTH = 1000;
   localparam int K_WEIGHT   = 5488;
   localparam int K_LENGTH   = 2000;

   // shared multiplier and search widths
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int NUM_W   = 31;
   localparam int DEN_W   = 26;
   localparam int WK_W    = 17;
   localparam int T_W     = 12;
   localparam logic [T_W-1:0] T_MAX = 12'hFFF;

   // entry: served mark, class, weight
   localparam int ENTRY_W = 7;

endpackage

// ===== rtl/tqqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tqqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/two_queue_quota_dispatcher_top.sv =====
// Two-side package dispatcher with quota switching and band transit time.
// Load, side-full and nothing-left items pass DECIDE and FINISH on their way to rsp_valid.
// Dispatch: a scan of the RAM over n slots, n the served side's load count, one slot
// a cycle, then 12 binary-search steps (SQ, SQD, CMP) on the shared multiplier.
// Too-weak band: no search after ST_MUL_N. A new item can be taken as rsp_valid rises.
// Synchronous reset restores the register defaults and empties both sides.
module two_queue_quota_dispatcher_top #(
   parameter int SIDE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic                   req_side,
   input  logic [3:0]             req_weight,
   input  logic [1:0]             req_pkg_class,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tqqd_pkg::status_type   rsp_status,
   output logic                   rsp_from_side,
   output logic [3:0]             rsp_slot,
   output logic [3:0]             rsp_out_weight,
   output logic [1:0]             rsp_out_class,
   output logic [tqqd_pkg::T_W-1:0] rsp_transit_time,
   output logic                   rsp_round_done,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wr_data
);
   import tqqd_pkg::*;

   localparam int IDX_W     = $clog2(SIDE_DEPTH);
   localparam int CNT_W     = $clog2(SIDE_DEPTH + 1);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_SCAN, ST_PICK, ST_FETCH,
      ST_MUL_S, ST_MUL_W, ST_MUL_L, ST_MUL_N, ST_NUM,
      ST_SQ, ST_SQD, ST_CMP, ST_COMMIT, ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration
   logic [7:0]  quota_w_ff;
   logic [1:0]  select_mode_ff;
   logic [15:0] strength_ff;
   logic [15:0] length_ff;

   // round state
   logic [CNT_W-1:0] loaded_ff [2];
   logic [CNT_W-1:0] served_ff [2];
   logic             cur_side_ff;
   logic [7:0]       quota_cnt_ff;

   // captured request
   logic       op_ff;
   logic       ld_side_ff;
   logic [3:0] ld_weight_ff;
   logic [1:0] ld_class_ff;

   // dispatch working state
   logic             sel_side_ff;
   logic [7:0]       sel_q_ff;
   logic [CNT_W-1:0] issue_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_slot_ff;
   logic             have_first_ff, have_c0_ff, have_c1_ff, have_light_ff;
   logic [IDX_W-1:0] first_ff, c0_ff, c1_ff, other_ff, light_ff;
   logic [3:0]       light_w_ff;
   logic [IDX_W-1:0] pick_ff;
   logic [3:0]       w_ff;
   logic [1:0]       c_ff;

   // arithmetic
   logic [PROD_W-1:0]  prod_ff;
   logic [DEN_W-1:0]   sk_ff;
   logic [WK_W-1:0]    wk_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [T_W-1:0]     lo_ff, hi_ff;

   // result being built, and output register
   status_type     res_status_ff;
   logic           res_side_ff;
   logic [3:0]     res_slot_ff;
   logic [3:0]     res_w_ff;
   logic [1:0]     res_c_ff;
   logic [T_W-1:0] res_t_ff;
   logic           res_done_ff;

   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic           rsp_side_ff;
   logic [3:0]     rsp_slot_ff;
   logic [3:0]     rsp_w_ff;
   logic [1:0]     rsp_c_ff;
   logic [T_W-1:0] rsp_t_ff;
   logic           rsp_done_ff;

   // combinational helpers
   logic [1:0]         rem_nz;
   logic [CNT_W-1:0]   scan_n;
   logic               side_full;
   logic [IDX_W-1:0]   pick_slot;
   logic [T_W-1:0]     mid;
   logic [T_W:0]       mid_sum;
   logic               search_ge;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_in;
   logic [CNT_W-1:0]   served_next;
   logic               rem_s_after;
   logic               rem_o;
   logic [7:0]         q_next;
   logic [7:0]         q_lim;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   assign rem_nz[0]   = loaded_ff[0] != served_ff[0];
   assign rem_nz[1]   = loaded_ff[1] != served_ff[1];
   assign scan_n      = loaded_ff[sel_side_ff];
   assign side_full   = loaded_ff[ld_side_ff] >= CNT_W'(SIDE_DEPTH);
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[T_W:1];
   assign search_ge   = prod_ff >= PROD_W'(num_ff);
   assign served_next = served_ff[sel_side_ff] + CNT_W'(1);
   assign rem_s_after = loaded_ff[sel_side_ff] != served_next;
   assign rem_o       = rem_nz[~sel_side_ff];
   assign q_next      = sel_q_ff + 8'd1;
   assign q_lim       = (quota_w_ff == 8'd0) ? 8'd1 : quota_w_ff;

   // priority: first class 0, else last class 1, else last of the rest; light: first lightest; order: first unserved
   always_comb begin
      unique case (select_mode_ff)
         SEL_PRIORITY: pick_slot = have_c0_ff ? c0_ff : (have_c1_ff ? c1_ff : other_ff);
         SEL_LIGHT:    pick_slot = light_ff;
         SEL_ORDER:    pick_slot = first_ff;
         default:      pick_slot = first_ff;
      endcase
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_S: begin
            mul_a = MUL_A_W'(strength_ff);
            mul_b = MUL_B_W'(K_STRENGTH);
         end
         ST_MUL_W: begin
            mul_a = MUL_A_W'(w_ff);
            mul_b = MUL_B_W'(K_WEIGHT);
         end
         ST_MUL_L: begin
            mul_a = MUL_A_W'(length_ff);
            mul_b = MUL_B_W'(K_LENGTH);
         end
         ST_MUL_N: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(w_ff);
         end
         ST_SQ: begin
            mul_a = MUL_A_W'(mid);
            mul_b = MUL_B_W'(mid);
         end
         ST_SQD: begin
            mul_a = MUL_A_W'(den_ff);
            mul_b = prod_ff[MUL_B_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // table RAM ports
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = {sel_side_ff, pick_ff};
      ram_wr_data = {1'b1, c_ff, w_ff};
      if (state_ff == ST_DECIDE && op_ff == OP_LOAD && !side_full) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {ld_side_ff, loaded_ff[ld_side_ff][IDX_W-1:0]};
         ram_wr_data = {1'b0, ld_class_ff, ld_weight_ff};
      end else if (state_ff == ST_COMMIT) begin
         ram_wr_en = 1'b1;
      end
   end

   assign ram_rd_addr = (state_ff == ST_SCAN) ? {sel_side_ff, issue_ff[IDX_W-1:0]}
                                              : {sel_side_ff, pick_slot};

   tqqd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         quota_w_ff     <= 8'd3;
         select_mode_ff <= SEL_LIGHT;
         strength_ff    <= 16'd100;
         length_ff      <= 16'd100;
         loaded_ff[0]   <= '0;
         loaded_ff[1]   <= '0;
         served_ff[0]   <= '0;
         served_ff[1]   <= '0;
         cur_side_ff    <= 1'b0;
         quota_cnt_ff   <= 8'd0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_QUOTA:    quota_w_ff     <= csr_wr_data[7:0];
               CSR_SELECT:   select_mode_ff <= csr_wr_data[1:0];
               CSR_STRENGTH: strength_ff    <= csr_wr_data;
               CSR_LENGTH:   length_ff      <= csr_wr_data;
            endcase
         end

         // in finish the output register is reloaded instead
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_opcode;
                  ld_side_ff   <= req_side;
                  ld_weight_ff <= req_weight;
                  ld_class_ff  <= req_pkg_class;
                  state_ff     <= ST_DECIDE;
               end
            end

            ST_DECIDE: begin
               res_side_ff <= 1'b0;
               res_slot_ff <= 4'd0;
               res_w_ff    <= 4'd0;
               res_c_ff    <= 2'd0;
               res_t_ff    <= '0;
               res_done_ff <= 1'b0;
               if (op_ff == OP_LOAD) begin
                  if (side_full) begin
                     res_status_ff <= STATUS_SIDE_FULL;
                  end else begin
                     res_status_ff         <= STATUS_LOADED;
                     loaded_ff[ld_side_ff] <= loaded_ff[ld_side_ff] + CNT_W'(1);
                  end
                  state_ff <= ST_FINISH;
               end else if (rem_nz == 2'b00) begin
                  res_status_ff <= STATUS_NOTHING;
                  state_ff      <= ST_FINISH;
               end else begin
                  // current side empty: take the other one and restart its quota
                  sel_side_ff   <= rem_nz[cur_side_ff] ? cur_side_ff : ~cur_side_ff;
                  sel_q_ff      <= rem_nz[cur_side_ff] ? quota_cnt_ff : 8'd0;
                  issue_ff      <= '0;
                  pend_ff       <= 1'b0;
                  have_first_ff <= 1'b0;
                  have_c0_ff    <= 1'b0;
                  have_c1_ff    <= 1'b0;
                  have_light_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               if (issue_ff < scan_n) begin
                  pend_slot_ff <= issue_ff[IDX_W-1:0];
                  issue_ff     <= issue_ff + CNT_W'(1);
                  pend_ff      <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_PICK;
               end
               if (pend_ff && !ram_rd_data[6]) begin
                  if (!have_first_ff) begin
                     have_first_ff <= 1'b1;
                     first_ff      <= pend_slot_ff;
                  end
                  if (ram_rd_data[5:4] == CLASS_RADIO) begin
                     if (!have_c0_ff) begin
                        have_c0_ff <= 1'b1;
                        c0_ff      <= pend_slot_ff;
                     end
                  end else if (ram_rd_data[5:4] == CLASS_URGENT) begin
                     have_c1_ff <= 1'b1;
                     c1_ff      <= pend_slot_ff;
                  end else begin
                     other_ff <= pend_slot_ff;
                  end
                  if (!have_light_ff || ram_rd_data[3:0] < light_w_ff) begin
                     have_light_ff <= 1'b1;
                     light_ff      <= pend_slot_ff;
                     light_w_ff    <= ram_rd_data[3:0];
                  end
               end
            end

            ST_PICK: begin
               pick_ff  <= pick_slot;
               state_ff <= ST_FETCH;
            end

            ST_FETCH: begin
               w_ff     <= ram_rd_data[3:0];
               c_ff     <= ram_rd_data[5:4];
               state_ff <= ST_MUL_S;
            end

            ST_MUL_S: state_ff <= ST_MUL_W;

            ST_MUL_W: begin
               sk_ff    <= prod_ff[DEN_W-1:0];
               state_ff <= ST_MUL_L;
            end

            ST_MUL_L: begin
               wk_ff    <= prod_ff[WK_W-1:0];
               state_ff <= ST_MUL_N;
            end

            ST_MUL_N: begin
               res_side_ff <= sel_side_ff;
               res_slot_ff <= 4'(pick_ff);
               res_w_ff    <= w_ff;
               res_c_ff    <= c_ff;
               res_t_ff    <= '0;
               res_done_ff <= 1'b0;
               if (sk_ff < DEN_W'(wk_ff)) begin
                  res_status_ff <= STATUS_TOO_WEAK;
                  state_ff      <= ST_FINISH;
               end else begin
                  den_ff   <= sk_ff - DEN_W'(wk_ff);
                  state_ff <= ST_NUM;
               end
            end

            ST_NUM: begin
               num_ff   <= prod_ff[NUM_W-1:0];
               lo_ff    <= '0;
               hi_ff    <= T_MAX;
               state_ff <= ST_SQ;
            end

            ST_SQ:  state_ff <= ST_SQD;
            ST_SQD: state_ff <= ST_CMP;

            // smallest t with t*t*den >= num; never satisfied saturates at the top
            ST_CMP: begin
               if (search_ge) begin
                  hi_ff    <= mid;
                  state_ff <= (lo_ff == mid) ? ST_COMMIT : ST_SQ;
               end else begin
                  lo_ff    <= mid + 12'd1;
                  state_ff <= (mid + 12'd1 == hi_ff) ? ST_COMMIT : ST_SQ;
               end
            end

            ST_COMMIT: begin
               res_status_ff <= STATUS_DISPATCHED;
               res_t_ff      <= lo_ff;
               // both sides exhausted: new round
               if (!rem_s_after && !rem_o) begin
                  loaded_ff[0] <= '0;
                  loaded_ff[1] <= '0;
                  served_ff[0] <= '0;
                  served_ff[1] <= '0;
                  cur_side_ff  <= 1'b0;
                  quota_cnt_ff <= 8'd0;
                  res_done_ff  <= 1'b1;
               end else begin
                  served_ff[sel_side_ff] <= served_next;
                  res_done_ff            <= 1'b0;
                  if (q_next >= q_lim) begin
                     quota_cnt_ff <= 8'd0;
                     cur_side_ff  <= rem_o ? ~sel_side_ff : sel_side_ff;
                  end else if (!rem_s_after) begin
                     quota_cnt_ff <= 8'd0;
                     cur_side_ff  <= ~sel_side_ff;
                  end else begin
                     quota_cnt_ff <= q_next;
                     cur_side_ff  <= sel_side_ff;
                  end
               end
               state_ff <= ST_FINISH;
            end

            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_side_ff   <= res_side_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_w_ff      <= res_w_ff;
                  rsp_c_ff      <= res_c_ff;
                  rsp_t_ff      <= res_t_ff;
                  rsp_done_ff   <= res_done_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_from_side    = rsp_side_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_out_weight   = rsp_w_ff;
   assign rsp_out_class    = rsp_c_ff;
   assign rsp_transit_time = rsp_t_ff;
   assign rsp_round_done   = rsp_done_ff;

   a_served_le_loaded: assert property (@(posedge clock) disable iff (reset)
      served_ff[0] <= loaded_ff[0] && served_ff[1] <= loaded_ff[1])
      else $error("served count exceeds loaded count");

   a_search_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> lo_ff < hi_ff)
      else $error("search interval collapsed before compare");

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DECIDE)
      else $error("accepted item not decoded");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

endmodule
